### src/gtvp_pkg.sv
// ----------------------------------------------------------------------------
// gtvp_pkg: shared types and constants of the gaze to view projection unit
// Field widths, register codes, reset values and inter-stage payloads.
// ----------------------------------------------------------------------------
package gtvp_pkg;

	localparam int QW      = 16;   // quaternion component, Q1.14
	localparam int UW      = QW + 1; // negated view component
	localparam int WD_W    = 26;   // world direction, Q.20
	localparam int CRD_W   = 20;   // Q3.16 values
	localparam int SPAN_W  = CRD_W + 1;
	localparam int DUV_W   = 45;
	localparam int SS_W    = 34;
	localparam int CR_W    = 44;
	localparam int RW      = 64;   // view direction, Q.48
	localparam int RX_W    = RW + 1;
	localparam int XW      = 44;   // view direction, Q.30
	localparam int NUM_W   = 66;
	localparam int MAG_W   = 64;
	localparam int QB      = 20;   // quotient bits, 3 integer + 17 fraction
	localparam int FRAC_B  = 17;
	localparam int REM_W   = 82;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 8 * QW;
	localparam int OUT_W   = 48;

	localparam logic signed [RW-1:0]     FWD_LIMIT = 64'sd28147497671;
	localparam logic signed [SPAN_W-1:0] SPAN_MIN  = 21'sd7;
	localparam logic signed [RX_W-1:0]   RND_Q30   = 65'sd131072;
	localparam logic signed [CRD_W-1:0]  CRD_MAX   = 20'sd524287;
	localparam logic signed [CRD_W-1:0]  CRD_MIN   = -20'sd524288;
	localparam logic [QB:0]              MAG_SAT   = 21'h100000;
	localparam logic [QB:0]              MAG_HALF  = 21'h080000;

	typedef enum logic [IDX_W-1:0] {
		REG_TAN_LEFT  = 3'd0,
		REG_TAN_RIGHT = 3'd1,
		REG_TAN_DOWN  = 3'd2,
		REG_TAN_UP    = 3'd3
	} reg_idx_t;

	typedef logic signed [QW-1:0] q_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	typedef struct packed {
		crd_t tu;
		crd_t td;
		crd_t tr;
		crd_t tl;
	} fov_t;

	localparam fov_t FOV_RST = '{tu: 20'sd65536, td: -20'sd65536,
		tr: 20'sd65536, tl: -20'sd65536};

	typedef struct packed {
		q_t vx;
		q_t vy;
		q_t vz;
		q_t vw;
		logic signed [WD_W-1:0] d0;
		logic signed [WD_W-1:0] d1;
		logic signed [WD_W-1:0] d2;
	} gaze_dir_t;

	typedef struct packed {
		logic             ok;
		logic             neg_u;
		logic [MAG_W-1:0] a_u;
		logic [MAG_W-1:0] d_u;
		logic             neg_v;
		logic [MAG_W-1:0] a_v;
		logic [MAG_W-1:0] d_v;
	} frac_t;

	typedef struct packed {
		logic clipped;
		crd_t v_coord;
		crd_t u_coord;
		logic ok;
	} res_t;

endpackage

### src/gtvp_rot_gaze.sv
// ----------------------------------------------------------------------------
// gtvp_rot_gaze: forward vector rotated by the gaze quaternion
// Two stages: component products, then sums with rounding to Q.20.
// ----------------------------------------------------------------------------
module gtvp_rot_gaze import gtvp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [IN_W-1:0] in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output gaze_dir_t       out_dir
);

	q_t gx, gy, gz, gw;
	logic signed [2*QW-1:0] p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1;
	logic signed [2*QW-1:0] p_ww_s1, p_zz_s1, p_xx_s1, p_yy_s1;
	q_t vx_s1, vy_s1, vz_s1, vw_s1;
	logic vld_s1, vld_s2, rdy_s1, rdy_s2;
	gaze_dir_t dir_s2, dir_nx;
	logic signed [33:0] a0, a1, b2, n0, n1, n2;

	assign gx = in_data[QW-1:0];
	assign gy = in_data[2*QW-1:QW];
	assign gz = in_data[3*QW-1:2*QW];
	assign gw = in_data[4*QW-1:3*QW];

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			p_xz_s1 <= gx * gz;
			p_wy_s1 <= gw * gy;
			p_yz_s1 <= gy * gz;
			p_wx_s1 <= gw * gx;
			p_ww_s1 <= gw * gw;
			p_zz_s1 <= gz * gz;
			p_xx_s1 <= gx * gx;
			p_yy_s1 <= gy * gy;
			vx_s1   <= in_data[5*QW-1:4*QW];
			vy_s1   <= in_data[6*QW-1:5*QW];
			vz_s1   <= in_data[7*QW-1:6*QW];
			vw_s1   <= in_data[8*QW-1:7*QW];
		end
		if (rdy_s2) dir_s2 <= dir_nx;
	end

	always_comb begin
		a0 = 34'(p_xz_s1) + 34'(p_wy_s1);
		a1 = 34'(p_yz_s1) - 34'(p_wx_s1);
		b2 = 34'(p_ww_s1) + 34'(p_zz_s1) - 34'(p_xx_s1) - 34'(p_yy_s1);
		n0 = 34'sd64 - a0;
		n1 = 34'sd64 - a1;
		n2 = 34'sd128 - b2;
		dir_nx.vx = vx_s1;
		dir_nx.vy = vy_s1;
		dir_nx.vz = vz_s1;
		dir_nx.vw = vw_s1;
		dir_nx.d0 = WD_W'(n0 >>> 7);
		dir_nx.d1 = WD_W'(n1 >>> 7);
		dir_nx.d2 = WD_W'(n2 >>> 8);
	end

	assign out_valid = vld_s2;
	assign out_dir   = dir_s2;

endmodule

### src/gtvp_rot_view.sv
// ----------------------------------------------------------------------------
// gtvp_rot_view: rotation by the view conjugate, forward test, numerators
// Stages s3..s9: products, sums, products, sum, rounding, fov products, abs.
// ----------------------------------------------------------------------------
module gtvp_rot_view import gtvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fov_t      fov,
	input  logic      in_valid,
	output logic      in_ready,
	input  gaze_dir_t in_dir,
	output logic      out_valid,
	input  logic      out_ready,
	output frac_t     out_frac
);

	logic signed [UW-1:0] ux, uy, uz;
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	logic signed [UW+WD_W-1:0] pd0_s3, pd1_s3, pd2_s3;
	logic signed [UW+WD_W-1:0] pca_s3, pcb_s3, pcc_s3, pcd_s3, pce_s3, pcf_s3;
	logic signed [2*QW-1:0] ww_s3, xx_s3, yy_s3, zz_s3;
	logic signed [UW-1:0] ux_s3, uy_s3, uz_s3, ux_s4, uy_s4, uz_s4;
	q_t w_s3, w_s4;
	logic signed [WD_W-1:0] d0_s3, d1_s3, d2_s3, d0_s4, d1_s4, d2_s4;

	logic signed [DUV_W-1:0] duv_s4;
	logic signed [SS_W-1:0]  ss_s4;
	logic signed [CR_W-1:0]  cx_s4, cy_s4, cz_s4;

	logic signed [DUV_W+UW-1:0] ma0_s5, ma1_s5, ma2_s5;
	logic signed [SS_W+WD_W-1:0] mb0_s5, mb1_s5, mb2_s5;
	logic signed [QW+CR_W-1:0]  mc0_s5, mc1_s5, mc2_s5;

	logic signed [RW-1:0] r0_s6, r1_s6, r2_s6;

	logic signed [RX_W-1:0] rx, ry, rz;
	logic signed [SPAN_W-1:0] width, height;
	logic signed [XW-1:0] x_s7, y_s7, nz_s7, x_s8, y_s8;
	logic ok_s7, ok_s8;

	logic signed [XW+CRD_W-1:0]  pl_s8, pu_s8;
	logic signed [XW+SPAN_W-1:0] dw_s8, dh_s8;

	logic signed [NUM_W-1:0] num_u, num_v, abs_u, abs_v;
	frac_t frac_s9;

	assign ux = -UW'(in_dir.vx);
	assign uy = -UW'(in_dir.vy);
	assign uz = -UW'(in_dir.vz);

	assign width  = SPAN_W'(fov.tr) - SPAN_W'(fov.tl);
	assign height = SPAN_W'(fov.tu) - SPAN_W'(fov.td);

	assign rdy_s9 = !vld_s9 || out_ready;
	assign rdy_s8 = !vld_s8 || rdy_s9;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= in_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	always_comb begin
		rx = RX_W'(r0_s6) + RND_Q30;
		ry = RX_W'(r1_s6) + RND_Q30;
		rz = RND_Q30 - RX_W'(r2_s6);
		num_u = (NUM_W'(x_s8) <<< 16) - NUM_W'(pl_s8);
		num_v = NUM_W'(pu_s8) - (NUM_W'(y_s8) <<< 16);
		abs_u = num_u[NUM_W-1] ? -num_u : num_u;
		abs_v = num_v[NUM_W-1] ? -num_v : num_v;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			pd0_s3 <= ux * in_dir.d0;
			pd1_s3 <= uy * in_dir.d1;
			pd2_s3 <= uz * in_dir.d2;
			pca_s3 <= uy * in_dir.d2;
			pcb_s3 <= uz * in_dir.d1;
			pcc_s3 <= uz * in_dir.d0;
			pcd_s3 <= ux * in_dir.d2;
			pce_s3 <= ux * in_dir.d1;
			pcf_s3 <= uy * in_dir.d0;
			ww_s3  <= in_dir.vw * in_dir.vw;
			xx_s3  <= in_dir.vx * in_dir.vx;
			yy_s3  <= in_dir.vy * in_dir.vy;
			zz_s3  <= in_dir.vz * in_dir.vz;
			ux_s3  <= ux;
			uy_s3  <= uy;
			uz_s3  <= uz;
			w_s3   <= in_dir.vw;
			d0_s3  <= in_dir.d0;
			d1_s3  <= in_dir.d1;
			d2_s3  <= in_dir.d2;
		end
		if (rdy_s4) begin
			duv_s4 <= DUV_W'(pd0_s3) + DUV_W'(pd1_s3) + DUV_W'(pd2_s3);
			ss_s4  <= SS_W'(ww_s3) - SS_W'(xx_s3) - SS_W'(yy_s3) - SS_W'(zz_s3);
			cx_s4  <= CR_W'(pca_s3) - CR_W'(pcb_s3);
			cy_s4  <= CR_W'(pcc_s3) - CR_W'(pcd_s3);
			cz_s4  <= CR_W'(pce_s3) - CR_W'(pcf_s3);
			ux_s4  <= ux_s3;
			uy_s4  <= uy_s3;
			uz_s4  <= uz_s3;
			w_s4   <= w_s3;
			d0_s4  <= d0_s3;
			d1_s4  <= d1_s3;
			d2_s4  <= d2_s3;
		end
		if (rdy_s5) begin
			ma0_s5 <= duv_s4 * ux_s4;
			ma1_s5 <= duv_s4 * uy_s4;
			ma2_s5 <= duv_s4 * uz_s4;
			mb0_s5 <= ss_s4 * d0_s4;
			mb1_s5 <= ss_s4 * d1_s4;
			mb2_s5 <= ss_s4 * d2_s4;
			mc0_s5 <= w_s4 * cx_s4;
			mc1_s5 <= w_s4 * cy_s4;
			mc2_s5 <= w_s4 * cz_s4;
		end
		if (rdy_s6) begin
			r0_s6 <= (RW'(ma0_s5) <<< 1) + RW'(mb0_s5) + (RW'(mc0_s5) <<< 1);
			r1_s6 <= (RW'(ma1_s5) <<< 1) + RW'(mb1_s5) + (RW'(mc1_s5) <<< 1);
			r2_s6 <= (RW'(ma2_s5) <<< 1) + RW'(mb2_s5) + (RW'(mc2_s5) <<< 1);
		end
		if (rdy_s7) begin
			x_s7  <= XW'(rx >>> 18);
			y_s7  <= XW'(ry >>> 18);
			nz_s7 <= XW'(rz >>> 18);
			ok_s7 <= (r2_s6 < -FWD_LIMIT) && (width >= SPAN_MIN) && (height >= SPAN_MIN);
		end
		if (rdy_s8) begin
			pl_s8 <= fov.tl * nz_s7;
			pu_s8 <= fov.tu * nz_s7;
			dw_s8 <= nz_s7 * width;
			dh_s8 <= nz_s7 * height;
			x_s8  <= x_s7;
			y_s8  <= y_s7;
			ok_s8 <= ok_s7;
		end
		if (rdy_s9) begin
			frac_s9.ok    <= ok_s8;
			frac_s9.neg_u <= num_u[NUM_W-1];
			frac_s9.a_u   <= abs_u[MAG_W-1:0];
			frac_s9.d_u   <= dw_s8[MAG_W-1:0];
			frac_s9.neg_v <= num_v[NUM_W-1];
			frac_s9.a_v   <= abs_v[MAG_W-1:0];
			frac_s9.d_v   <= dh_s8[MAG_W-1:0];
		end
	end

	assign out_valid = vld_s9;
	assign out_frac  = frac_s9;

endmodule

### src/gtvp_div.sv
// ----------------------------------------------------------------------------
// gtvp_div: pipelined restoring divider for u and v, then round and clamp
// One quotient bit per stage for both lanes, result register at the end.
// ----------------------------------------------------------------------------
module gtvp_div import gtvp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  frac_t in_frac,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	logic             vld_s [QB];
	logic             rdy_s [QB];
	logic             ok_s  [QB];
	logic [REM_W-1:0] rem_s [QB][2];
	logic [MAG_W-1:0] dvs_s [QB][2];
	logic [QB-1:0]    quo_s [QB][2];
	logic             neg_s [QB][2];
	logic             sat_s [QB][2];

	logic [REM_W-1:0] rem_in [QB][2];
	logic [MAG_W-1:0] dvs_in [QB][2];
	logic [QB-1:0]    quo_in [QB][2];
	logic             neg_in [QB][2];
	logic             sat_in [QB][2];
	logic             ok_in  [QB];
	logic [REM_W-1:0] rem_nx [QB][2];
	logic [QB-1:0]    quo_nx [QB][2];
	logic [REM_W-1:0] shd    [QB][2];

	logic [MAG_W-1:0] a0 [2];
	logic [QB:0]      mag [2];
	logic             clp [2];
	crd_t             val [2];

	logic vld_s30, rdy_s30;
	res_t res_s30, res_nx;

	assign a0[0] = in_frac.a_u;
	assign a0[1] = in_frac.a_v;

	always_comb begin
		rdy_s30 = !vld_s30 || out_ready;
		rdy_s[QB-1] = !vld_s[QB-1] || rdy_s30;
		for (int i = QB - 2; i >= 0; i--) begin
			rdy_s[i] = !vld_s[i] || rdy_s[i+1];
		end
	end
	assign in_ready = rdy_s[0];

	always_comb begin
		ok_in[0]     = in_frac.ok;
		dvs_in[0][0] = in_frac.d_u;
		dvs_in[0][1] = in_frac.d_v;
		neg_in[0][0] = in_frac.neg_u;
		neg_in[0][1] = in_frac.neg_v;
		for (int l = 0; l < 2; l++) begin
			rem_in[0][l] = REM_W'(a0[l]) << FRAC_B;
			quo_in[0][l] = '0;
			sat_in[0][l] = ({3'b000, a0[l]} >= {dvs_in[0][l], 3'b000});
		end
		for (int i = 1; i < QB; i++) begin
			ok_in[i] = ok_s[i-1];
			for (int l = 0; l < 2; l++) begin
				rem_in[i][l] = rem_s[i-1][l];
				dvs_in[i][l] = dvs_s[i-1][l];
				quo_in[i][l] = quo_s[i-1][l];
				neg_in[i][l] = neg_s[i-1][l];
				sat_in[i][l] = sat_s[i-1][l];
			end
		end
		for (int i = 0; i < QB; i++) begin
			for (int l = 0; l < 2; l++) begin
				shd[i][l] = REM_W'(dvs_in[i][l]) << (QB - 1 - i);
				if (rem_in[i][l] >= shd[i][l]) begin
					rem_nx[i][l] = rem_in[i][l] - shd[i][l];
					quo_nx[i][l] = quo_in[i][l] | (QB'(1) << (QB - 1 - i));
				end else begin
					rem_nx[i][l] = rem_in[i][l];
					quo_nx[i][l] = quo_in[i][l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) vld_s[i] <= 1'b0;
			vld_s30 <= 1'b0;
		end else begin
			if (rdy_s[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < QB; i++) begin
				if (rdy_s[i]) vld_s[i] <= vld_s[i-1];
			end
			if (rdy_s30) vld_s30 <= vld_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QB; i++) begin
			if (rdy_s[i]) begin
				ok_s[i] <= ok_in[i];
				for (int l = 0; l < 2; l++) begin
					rem_s[i][l] <= rem_nx[i][l];
					dvs_s[i][l] <= dvs_in[i][l];
					quo_s[i][l] <= quo_nx[i][l];
					neg_s[i][l] <= neg_in[i][l];
					sat_s[i][l] <= sat_in[i][l];
				end
			end
		end
		if (rdy_s30) res_s30 <= res_nx;
	end

	// round half away from zero, then clamp to Q3.16
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l] = sat_s[QB-1][l] ? MAG_SAT :
				(((QB+1)'(quo_s[QB-1][l]) + (QB+1)'(1)) >> 1);
			if (neg_s[QB-1][l]) begin
				clp[l] = mag[l] > MAG_HALF;
				val[l] = clp[l] ? CRD_MIN : CRD_W'(-mag[l]);
			end else begin
				clp[l] = mag[l] >= MAG_HALF;
				val[l] = clp[l] ? CRD_MAX : CRD_W'(mag[l]);
			end
		end
		res_nx.ok      = ok_s[QB-1];
		res_nx.u_coord = ok_s[QB-1] ? val[0] : '0;
		res_nx.v_coord = ok_s[QB-1] ? val[1] : '0;
		res_nx.clipped = ok_s[QB-1] && (clp[0] || clp[1]);
	end

	assign out_valid = vld_s30;
	assign out_res   = res_s30;

endmodule

### src/gaze_to_view_projection_unit.sv
// ----------------------------------------------------------------------------
// gaze_to_view_projection_unit: gaze direction to normalized view u,v
// Rotates forward by the gaze quaternion and the view conjugate, projects.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per sample: gaze and view quaternions, Q1.14.
//   m_axis returns one beat per sample: ok, u_coord, v_coord, clipped.
//   The cfg port writes the four fov tangents (Q3.16) by index, one per
//   cycle; indexes above three are ignored. The user must write them only
//   while no sample is in flight; the block itself has no check for this.
//   The pipe holds nine stages of rotation and scaling, the 20 one-bit
//   stages of the u/v divider and the round/clamp output register.
//   Throughput is one beat per cycle while m_axis_tready stays high.
//   Each stage moves on when its successor has room, so bubbles collapse
//   and input is taken while a finished beat waits at the output.
//   When the receiver stalls, the pipe fills up, then s_axis_tready drops.
//   Reset empties the pipe and loads tangents -1, +1, -1, +1.
//   Rejected samples return ok=0 with all other fields zero.
// ----------------------------------------------------------------------------
module gaze_to_view_projection_unit import gtvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// gaze_qx, gaze_qy, gaze_qz, gaze_qw, view_qx, view_qy, view_qz, view_qw
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// ok, u_coord, v_coord, clipped, zero pad
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CRD_W-1:0] cfg_data
);

	fov_t fov_q;
	logic g_vld, g_rdy, f_vld, f_rdy;
	gaze_dir_t g_dir;
	frac_t f_frac;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q <= FOV_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TAN_LEFT:  fov_q.tl <= cfg_data;
				REG_TAN_RIGHT: fov_q.tr <= cfg_data;
				REG_TAN_DOWN:  fov_q.td <= cfg_data;
				REG_TAN_UP:    fov_q.tu <= cfg_data;
				default: ;
			endcase
		end
	end

	gtvp_rot_gaze u_rot_gaze (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (g_vld),
		.out_ready (g_rdy),
		.out_dir   (g_dir)
	);

	gtvp_rot_view u_rot_view (
		.clk       (clk),
		.arst_n    (arst_n),
		.fov       (fov_q),
		.in_valid  (g_vld),
		.in_ready  (g_rdy),
		.in_dir    (g_dir),
		.out_valid (f_vld),
		.out_ready (f_rdy),
		.out_frac  (f_frac)
	);

	gtvp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_vld),
		.in_ready  (f_rdy),
		.in_frac   (f_frac),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {(OUT_W - $bits(res_t))'(0), res};

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.ok |-> (res.u_coord == '0) && (res.v_coord == '0)
			&& !res.clipped)
		else $error("rejected beat carries nonzero fields");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.clipped |-> res.ok && ((res.u_coord == CRD_MAX) ||
			(res.u_coord == CRD_MIN) || (res.v_coord == CRD_MAX) ||
			(res.v_coord == CRD_MIN)))
		else $error("clipped beat without a saturated coordinate");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("pipe blocks input while output drains");

endmodule

### dv/gaze_to_view_projection_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaze_to_view_projection_unit_tb: self-checking bench for the gaze projector
// Streams gaze/view quaternion pairs under several fov tangent settings and
// random handshake pressure. A bit-exact integer predictor computes each
// expected u/v result, and every output beat is compared in order.
// ----------------------------------------------------------------------------
module gaze_to_view_projection_unit_tb;
	import gtvp_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam longint FWD_MIN_Q48 = 64'sd28147497671;
	localparam longint MIN_SPAN = 7;
	localparam int SETTLE = 40;
	localparam int LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [CRD_W-1:0] cfg_data;

	longint fov_l, fov_r, fov_d, fov_u;
	logic [IN_W-1:0] pending_beats[$];
	res_t expected_uv[$];
	int  errors = 0;
	int  cycles = 0;
	int  tx_idle = 0;
	int  rx_idle = 0;
	bit  in_fire = 0;
	bit  want_stall = 0;
	bit  stall_done = 0;
	int  stall_cnt = 0;

	gaze_to_view_projection_unit DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic void rotate(input longint q[4], input longint v[3],
			output longint r[3]);
		longint duv, s, cx, cy, cz;
		duv = q[0] * v[0] + q[1] * v[1] + q[2] * v[2];
		s = q[3] * q[3] - (q[0] * q[0] + q[1] * q[1] + q[2] * q[2]);
		cx = q[1] * v[2] - q[2] * v[1];
		cy = q[2] * v[0] - q[0] * v[2];
		cz = q[0] * v[1] - q[1] * v[0];
		r[0] = 2 * duv * q[0] + s * v[0] + 2 * q[3] * cx;
		r[1] = 2 * duv * q[1] + s * v[1] + 2 * q[3] * cy;
		r[2] = 2 * duv * q[2] + s * v[2] + 2 * q[3] * cz;
	endfunction

	function automatic longint q16_ratio(input longint num, input longint den,
			inout bit clip);
		longint unsigned a, d, ip, r, frac;
		longint mag, val;
		bit neg;
		neg = num < 0;
		a = neg ? longint'(-num) : num;
		d = den;
		ip = a / d;
		if (ip >= 8) begin
			mag = longint'(1) << 20;
		end else begin
			r = a % d;
			frac = 0;
			for (int i = 0; i < 17; i++) begin
				r = r << 1;
				frac = frac << 1;
				if (r >= d) begin
					r = r - d;
					frac = frac | 1;
				end
			end
			mag = (((ip << 17) | frac) + 1) >> 1;
		end
		val = neg ? -mag : mag;
		if (val > CRD_MAX) begin
			clip = 1;
			return CRD_MAX;
		end
		if (val < CRD_MIN) begin
			clip = 1;
			return CRD_MIN;
		end
		return val;
	endfunction

	function automatic res_t project_gaze(input logic [IN_W-1:0] d);
		longint gq[4], vq[4], fwd[3], wq[3], wd[3], vd[3];
		longint width, height, x, y, nz;
		bit clip;
		res_t res;
		clip = 0;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			gq[i] = q_t'(d[QW*i +: QW]);
			vq[i] = q_t'(d[QW*(4+i) +: QW]);
		end
		for (int i = 0; i < 3; i++) vq[i] = -vq[i];
		fwd[0] = 0;
		fwd[1] = 0;
		fwd[2] = -(longint'(1) << 20);
		rotate(gq, fwd, wq);
		for (int i = 0; i < 3; i++) wd[i] = (wq[i] + (longint'(1) << 27)) >>> 28;
		rotate(vq, wd, vd);
		width = fov_r - fov_l;
		height = fov_u - fov_d;
		if (-vd[2] <= FWD_MIN_Q48 || width < MIN_SPAN || height < MIN_SPAN)
			return res;
		x = (vd[0] + (longint'(1) << 17)) >>> 18;
		y = (vd[1] + (longint'(1) << 17)) >>> 18;
		nz = (-vd[2] + (longint'(1) << 17)) >>> 18;
		res.ok = 1;
		res.u_coord = crd_t'(q16_ratio(x * 65536 - fov_l * nz, nz * width, clip));
		res.v_coord = crd_t'(q16_ratio(fov_u * nz - y * 65536, nz * height, clip));
		res.clipped = clip;
		return res;
	endfunction

	function automatic logic [IN_W-1:0] pack_quats(input int c[8]);
		logic [IN_W-1:0] d;
		for (int i = 0; i < 8; i++) d[QW*i +: QW] = q_t'(c[i]);
		return d;
	endfunction

	function automatic int pick_comp(input int mode, input bit is_w);
		int e;
		case (mode)
			0: return int'($urandom_range(32768)) - 16384;
			1: begin
				if (is_w) return 16384 - int'($urandom_range(3000));
				return int'($urandom_range(12000)) - 6000;
			end
			default: begin
				e = $urandom_range(3);
				if (e == 0) return -16384;
				if (e == 1) return 16384;
				if (e == 2) return 0;
				return int'($urandom_range(32768)) - 16384;
			end
		endcase
	endfunction

	task automatic add_random(input int n);
		int c[8];
		int m, sel;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(9);
			m = sel < 4 ? 0 : (sel < 8 ? 1 : 2);
			for (int i = 0; i < 8; i++) c[i] = pick_comp(m, (i % 4) == 3);
			pending_beats.push_back(pack_quats(c));
		end
	endtask

	task automatic add_beat(input int gx, gy, gz, gw, vx, vy, vz, vw);
		int c[8];
		c = '{gx, gy, gz, gw, vx, vy, vz, vw};
		pending_beats.push_back(pack_quats(c));
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input longint val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CRD_W-1:0];
		case (idx)
			REG_TAN_LEFT:  fov_l = val;
			REG_TAN_RIGHT: fov_r = val;
			REG_TAN_DOWN:  fov_d = val;
			REG_TAN_UP:    fov_u = val;
			default: ;
		endcase
	endtask

	task automatic set_fov(input longint l, r, dn, up);
		write_reg(REG_TAN_LEFT, l);
		write_reg(REG_TAN_RIGHT, r);
		write_reg(REG_TAN_DOWN, dn);
		write_reg(REG_TAN_UP, up);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (pending_beats.size() != 0 || s_axis_tvalid || expected_uv.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// input side: beat stays up until taken
	always @(posedge clk) in_fire <= s_axis_tvalid && s_axis_tready;

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			expected_uv.push_back(project_gaze(s_axis_tdata));
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_beats.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (want_stall && !stall_done) begin
			stall_done <= 1'b1;
			stall_cnt <= 300;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= rx_idle;
		end
	end

	always @(posedge clk) begin
		res_t got, exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(res_t)-1:0];
			if (expected_uv.size() == 0) begin
				$error("unexpected output beat %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_uv.pop_front();
				if (got.ok !== exp_r.ok) begin
					$error("ok expected %0d got %0d", exp_r.ok, got.ok);
					errors++;
				end
				if (got.u_coord !== exp_r.u_coord) begin
					$error("u_coord expected %0d got %0d", exp_r.u_coord, got.u_coord);
					errors++;
				end
				if (got.v_coord !== exp_r.v_coord) begin
					$error("v_coord expected %0d got %0d", exp_r.v_coord, got.v_coord);
					errors++;
				end
				if (got.clipped !== exp_r.clipped) begin
					$error("clipped expected %0d got %0d", exp_r.clipped, got.clipped);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[gaze_to_view_projection_unit] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_TAN_LEFT;
		cfg_data = '0;
		fov_l = -65536;
		fov_r = 65536;
		fov_d = -65536;
		fov_u = 65536;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// reset tangents, directed corners first
		tx_idle = 15;
		rx_idle = 84;
		add_beat(0, 0, 0, 0, 0, 0, 0, 0);
		add_beat(0, 0, 0, 16384, 0, 0, 0, 16384);
		add_beat(0, 0, 0, -16384, 0, 0, 0, -16384);
		add_beat(16384, 0, 0, 0, 0, 0, 0, 16384);
		add_beat(0, 16384, 0, 0, 0, 0, 0, 16384);
		add_beat(0, 0, 16384, 0, 0, 0, 0, 16384);
		add_beat(16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384);
		add_beat(-16384, -16384, -16384, 16384, 16384, 16384, 16384, 16384);
		add_beat(0, 8192, 0, 14189, 0, 0, 0, 16384);
		add_beat(8192, 0, 0, 14189, 0, 0, 0, 16384);
		add_beat(0, -11585, 0, 11585, 0, 0, 0, 16384);
		add_beat(0, 0, 0, 16384, 0, 11585, 0, 11585);
		add_beat(1000, -2000, 500, 16000, -300, 700, 100, 16300);
		add_beat(0, 3000, 0, 16100, 0, 3000, 0, 16100);
		add_beat(0, 0, 0, 100, 0, 0, 0, 100);
		add_beat(0, 0, 0, 1, 0, 0, 0, 1);
		add_beat(-16384, 16384, -16384, 16384, 0, 0, 16384, 0);
		add_random(350);
		drain();

		// widest tangents, plus an ignored register index
		set_fov(-524288, 524287, -524288, 524287);
		write_reg(REG_UNUSED, 12345);
		@(negedge clk);
		cfg_we <= 1'b0;
		tx_idle = 84;
		rx_idle = 15;
		add_random(300);
		drain();

		// narrowest valid spans, long output stall
		set_fov(0, 7, -3, 4);
		tx_idle = 0;
		rx_idle = 0;
		want_stall = 1;
		add_random(150);
		drain();

		// width span one below the minimum: all rejected
		set_fov(100, 106, -10, 90);
		add_random(50);
		drain();

		// skewed asymmetric fov, sender pauses until drained mid-phase
		set_fov(-30000, 90000, -200000, 5000);
		add_random(150);
		drain();
		add_random(150);
		drain();

		if (errors == 0)
			$display("[gaze_to_view_projection_unit] OK");
		else
			$display("[gaze_to_view_projection_unit] ERROR");
		$finish;
	end

endmodule
